// ===== rtl/ica_pkg.sv =====
// Package: shared constants, opcodes, status codes and pipeline token type for the calculator ALU.
`timescale 1ns / 1ps
package ica_pkg;
    localparam int OperandWidth = 31;
    localparam int ResultWidth  = 63;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_MUL  = 3'd1;
    localparam logic [2:0] OP_DIV  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_REM  = 3'd4;
    localparam logic [2:0] OP_SQR  = 3'd5;
    localparam logic [2:0] OP_SQRT = 3'd6;
    localparam logic [2:0] OP_LOG  = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_LOG_ZERO = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [2:0] opcode;
        logic [1:0] status;
    } ica_ctl_t;
endpackage

// ===== rtl/ica_cell.sv =====
// One cell of the iterative chain: a restoring divide step or a root step on a held item.
`timescale 1ns / 1ps
module ica_cell #(
    parameter int W = ica_pkg::OperandWidth,
    parameter int K = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ica_pkg::ica_ctl_t   ctl_in,
    input  logic [W-1:0]        num_in,
    input  logic [W-1:0]        den_in,
    input  logic [W:0]          rem_in,
    input  logic [W-1:0]        quo_in,
    input  logic [2*W+1:0]      pass_in,
    output ica_pkg::ica_ctl_t   ctl_out,
    output logic [W-1:0]        num_out,
    output logic [W-1:0]        den_out,
    output logic [W:0]          rem_out,
    output logic [W-1:0]        quo_out,
    output logic [2*W+1:0]      pass_out
);
    // divide: step K handles numerator bit W-1-K
    // sqrt:   rem holds partial remainder, quo the root so far; pair index K < (W+1)/2
    localparam int NPair = (W + 1) / 2;
    localparam int PIdx  = (K < NPair) ? (NPair - 1 - K) : 0;
    localparam int HiOk  = ((2*PIdx + 1) < W) ? 1 : 0;
    localparam int HiIdx = (HiOk != 0) ? (2*PIdx + 1) : (2*PIdx);
    logic [W+1:0] trial;
    logic [W+1:0] shifted;
    logic [W:0]   rem_next;
    logic [W-1:0] quo_next;
    logic         is_root;
    logic [1:0]   pair;
    logic [W+1:0] root_trial;

    always_comb
    begin
        is_root    = (ctl_in.opcode == ica_pkg::OP_SQRT);
        rem_next   = rem_in;
        quo_next   = quo_in;
        pair       = 2'b00;
        shifted    = '0;
        trial      = '0;
        root_trial = '0;
        if (is_root)
        begin
            if (K < NPair)
            begin
                pair[1] = (HiOk != 0) ? num_in[HiIdx] : 1'b0;
                pair[0] = num_in[2*PIdx];
                shifted    = {rem_in[W-1:0], pair};
                root_trial = {quo_in, 2'b01};
                if (shifted >= root_trial)
                begin
                    trial    = shifted - root_trial;
                    rem_next = trial[W:0];
                    quo_next = {quo_in[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[W:0];
                    quo_next = {quo_in[W-2:0], 1'b0};
                end
            end
        end
        else
        begin
            shifted = {1'b0, rem_in[W-1:0], num_in[W-1-K]};
            if (shifted >= {2'b00, den_in})
            begin
                trial    = shifted - {2'b00, den_in};
                rem_next = trial[W:0];
                quo_next = {quo_in[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W:0];
                quo_next = {quo_in[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_out <= '0;
        else if (en)
            ctl_out <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_out  <= num_in;
            den_out  <= den_in;
            rem_out  <= rem_next;
            quo_out  <= quo_next;
            pass_out <= pass_in;
        end
    end
endmodule

// ===== rtl/ica_front.sv =====
// Input stage: decodes the op, computes the add and subtract results, log2, and status.
`timescale 1ns / 1ps
module ica_front #(
    parameter int W = ica_pkg::OperandWidth
) (
    input  logic [2:0]          opcode,
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    output ica_pkg::ica_ctl_t   ctl,
    output logic [2*W+1:0]      early
);
    localparam int LW = $clog2(W + 1);
    logic [W-1:0] am1;
    logic [LW-1:0] lg;
    logic [W:0]   sum;
    logic [W:0]   dif;

    always_comb
    begin
        am1 = a - {{(W-1){1'b0}}, 1'b1};
        lg  = '0;
        for (int i = 0; i < W; i++)
        begin
            if (am1[i])
                lg = LW'(i + 1);
        end
        sum = {1'b0, a} + {1'b0, b};
        dif = {1'b0, a} - {1'b0, b};
        ctl.valid  = 1'b1;
        ctl.opcode = opcode;
        ctl.status = ica_pkg::ST_OK;
        early      = '0;
        case (opcode)
            ica_pkg::OP_ADD:
                early = {{(W+1){1'b0}}, sum};
            ica_pkg::OP_SUB:
                early = {{(W+1){dif[W]}}, dif};
            ica_pkg::OP_DIV, ica_pkg::OP_REM:
                if (b == '0)
                    ctl.status = ica_pkg::ST_DIV_ZERO;
            ica_pkg::OP_LOG:
                if (a == '0)
                    ctl.status = ica_pkg::ST_LOG_ZERO;
                else
                    early = (2*W+2)'(lg);
            default:
                early = '0;
        endcase
    end
endmodule

// ===== rtl/integer_calculator_alu.sv =====
// Top level: stream-in integer calculator with a chain of divide/root cells and a multiplier.
//  channel | group     | contents
//  in      | s_axis_*  | tdata = opcode[2:0], operand_a, operand_b
//  out     | m_axis_*  | tdata = result[62:0], status[64:63]
// The path is W chain cells plus the output register; one transfer per cycle unless the out side stalls.
// The chain advances whenever the output register is empty or being taken, so a stall on the
// out side holds the whole chain. Reset clears all valid flags; payload is not reset.
`timescale 1ns / 1ps
module integer_calculator_alu #(
    parameter int OPERAND_WIDTH = ica_pkg::OperandWidth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // opcode, operand_a, operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // result, status
);
    localparam int W = OPERAND_WIDTH;
    localparam int PW = 2*W + 2;

    logic [2:0]   opcode;
    logic [W-1:0] a_in;
    logic [W-1:0] b_in;
    logic         en;

    assign opcode = s_axis_tdata[2:0];
    assign a_in   = s_axis_tdata[3 +: W];
    assign b_in   = s_axis_tdata[34 +: W];

    ica_pkg::ica_ctl_t f_ctl;
    logic [PW-1:0]     f_early;

    ica_front #(.W(W)) u_front (
        .opcode(opcode), .a(a_in), .b(b_in), .ctl(f_ctl), .early(f_early)
    );

    ica_pkg::ica_ctl_t c_ctl [0:W];
    logic [W-1:0]      c_num [0:W];
    logic [W-1:0]      c_den [0:W];
    logic [W:0]        c_rem [0:W];
    logic [W-1:0]      c_quo [0:W];
    logic [PW-1:0]     c_pass[0:W];
    logic [2*W-1:0]    prod_reg;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        c_ctl[0]       = f_ctl;
        c_ctl[0].valid = s_axis_tvalid;
        c_num[0]       = a_in;
        c_den[0]       = b_in;
        c_rem[0]       = '0;
        c_quo[0]       = '0;
        c_pass[0]      = f_early;
    end

    for (genvar k = 0; k < W; k++)
    begin : g_cell
        ica_cell #(.W(W), .K(k)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctl_in(c_ctl[k]), .num_in(c_num[k]), .den_in(c_den[k]),
            .rem_in(c_rem[k]), .quo_in(c_quo[k]), .pass_in(c_pass[k]),
            .ctl_out(c_ctl[k+1]), .num_out(c_num[k+1]), .den_out(c_den[k+1]),
            .rem_out(c_rem[k+1]), .quo_out(c_quo[k+1]), .pass_out(c_pass[k+1])
        );
    end

    // product computed at cell 1 from held operands; prod_pipe[k] travels with c_ctl[k+1]
    logic [W-1:0] mb;
    logic [2*W-1:0] prod_pipe [1:W-1];
    assign mb = (c_ctl[1].opcode == ica_pkg::OP_SQR) ? c_num[1] : c_den[1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (2*W)'(c_num[1]) * (2*W)'(mb);
        end
    end
    assign prod_pipe[1] = prod_reg;
    for (genvar k = 2; k < W; k++)
    begin : g_prod
        logic [2*W-1:0] p_reg;
        always_ff @(posedge clk)
        begin
            if (en)
                p_reg <= prod_pipe[k-1];
        end
        assign prod_pipe[k] = p_reg;
    end

    logic [62:0] res_next;
    logic [62:0] res_reg;
    logic [1:0]  st_reg;
    ica_pkg::ica_ctl_t t;
    logic [W-1:0] root;

    always_comb
    begin
        t        = c_ctl[W];
        root     = c_quo[W];
        res_next = 63'(c_pass[W]);
        if (t.status != ica_pkg::ST_OK)
            res_next = '0;
        else
        begin
            case (t.opcode)
                ica_pkg::OP_MUL, ica_pkg::OP_SQR:
                    res_next = 63'(prod_pipe[W-1]);
                ica_pkg::OP_DIV:
                    res_next = 63'(c_quo[W]);
                ica_pkg::OP_REM:
                    res_next = 63'(c_rem[W]);
                ica_pkg::OP_SQRT:
                    res_next = 63'(root);
                ica_pkg::OP_SUB:
                    res_next = 63'($signed(c_pass[W]));
                default:
                    res_next = 63'(c_pass[W]);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (en)
            m_axis_tvalid <= t.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            st_reg  <= t.status;
        end
    end

    assign m_axis_tdata = {7'd0, st_reg, res_reg};
endmodule

// ===== tb/sv/integer_calculator_alu_tb.sv =====
// Testbench: random and directed streams through the calculator ALU, checked against a predictor.
`timescale 1ns / 1ps
module integer_calculator_alu_tb;
    localparam int NUM_RANDOM = 1525;
    localparam int LATENCY    = ica_pkg::OperandWidth + 2;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [30:0] operand_a;
        logic [30:0] operand_b;
    } calc_req_t;

    typedef struct packed {
        logic [62:0] result;
        logic [1:0]  status;
    } calc_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // opcode[2:0], operand_a[33:3], operand_b[64:34]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // result[62:0], status[64:63]

    calc_req_t pending_reqs[$];
    calc_rsp_t expected_rsps[$];
    int        errors;
    int        idle_cycles;
    int        hold_cycles;
    int        burst_left;
    int        gap_left;
    int        stall_phase;
    bit        stim_done;
    bit        pause_req;
    bit        hold_req;
    bit        in_xfer;

    integer_calculator_alu i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [62:0] isqrt(logic [62:0] v);
        logic [62:0] r;
        r = 0;
        for (int k = 31; k >= 0; k--)
        begin
            logic [63:0] t;
            t = r | (64'd1 << k);
            if (t * t <= v)
                r = t[62:0];
        end
        return r;
    endfunction

    function automatic calc_rsp_t compute_calc(calc_req_t q);
        calc_rsp_t   p;
        logic [62:0] a;
        logic [62:0] b;
        a = {32'd0, q.operand_a};
        b = {32'd0, q.operand_b};
        p.result = '0;
        p.status = ica_pkg::ST_OK;
        case (q.opcode)
            ica_pkg::OP_ADD:  p.result = a + b;
            ica_pkg::OP_MUL:  p.result = a * b;
            ica_pkg::OP_DIV:
                if (b == 0) p.status = ica_pkg::ST_DIV_ZERO; else p.result = a / b;
            ica_pkg::OP_SUB:  p.result = a - b;
            ica_pkg::OP_REM:
                if (b == 0) p.status = ica_pkg::ST_DIV_ZERO; else p.result = a % b;
            ica_pkg::OP_SQR:  p.result = a * a;
            ica_pkg::OP_SQRT: p.result = isqrt(a);
            default:
            begin
                if (a == 0)
                    p.status = ica_pkg::ST_LOG_ZERO;
                else
                    while ((63'd1 << p.result) < a)
                        p.result++;
            end
        endcase
        return p;
    endfunction

    function automatic logic [30:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 3));
            1: return 31'h7fffffff - 31'($urandom_range(0, 3));
            2: return 31'd1 << $urandom_range(0, 30);
            3: return 31'($urandom_range(0, 255));
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic add_req(logic [2:0] op, logic [30:0] a, logic [30:0] b);
        calc_req_t q;
        q.opcode = op;
        q.operand_a = a;
        q.operand_b = b;
        pending_reqs.push_back(q);
    endtask

    initial
    begin
        errors = 0;
        stim_done = 0;
        pause_req = 0;
        hold_req = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int op = 0; op < 8; op++)
        begin
            add_req(3'(op), 31'h7fffffff, 31'h7fffffff);
            add_req(3'(op), 31'd0, 31'd0);
        end
        add_req(ica_pkg::OP_SUB, 31'd0, 31'h7fffffff);
        add_req(ica_pkg::OP_DIV, 31'd5, 31'd0);
        add_req(ica_pkg::OP_REM, 31'h7fffffff, 31'd0);
        add_req(ica_pkg::OP_LOG, 31'd1, 31'd9);
        add_req(ica_pkg::OP_LOG, 31'h40000001, 31'd0);
        add_req(ica_pkg::OP_SQRT, 31'd15, 31'd0);
        add_req(ica_pkg::OP_REM, 31'd17, 31'd5);
        wait (pending_reqs.size() == 0);
        pause_req = 1;
        wait (expected_rsps.size() == 0);
        pause_req = 0;
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == 300)
                hold_req = 1;
            add_req(3'($urandom_range(0, 7)), rand_operand(), rand_operand());
        end
        wait (pending_reqs.size() == 0);
        stim_done = 1;
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!s_axis_tvalid || in_xfer)
        begin
            if (gap_left > 0)
                gap_left--;
            if (in_xfer)
                void'(pending_reqs.pop_front());
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (!pause_req && gap_left == 0 && pending_reqs.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, pending_reqs[0].operand_b,
                                  pending_reqs[0].operand_a, pending_reqs[0].opcode};
                burst_left--;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern and long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles = 0;
            stall_phase = 0;
        end
        else
        begin
            stall_phase++;
            if (hold_req && hold_cycles < 200)
            begin
                hold_cycles++;
                m_axis_tready <= 1'b0;
            end
            else if (stall_phase % 512 < 128)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        in_xfer = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_xfer)
        begin
            calc_req_t q;
            q = calc_req_t'({s_axis_tdata[2:0], s_axis_tdata[33:3], s_axis_tdata[64:34]});
            expected_rsps.push_back(compute_calc(q));
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            calc_rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result transfer %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (m_axis_tdata[62:0] !== want.result)
                begin
                    $error("result: expected %h, actual %h", want.result, m_axis_tdata[62:0]);
                    errors++;
                end
                if (m_axis_tdata[64:63] !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status,
                           m_axis_tdata[64:63]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_rsps.size() == 0);
        repeat (4 * LATENCY) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== integer_calculator_alu.f =====
rtl/ica_pkg.sv
rtl/ica_cell.sv
rtl/ica_front.sv
rtl/integer_calculator_alu.sv
tb/sv/integer_calculator_alu_tb.sv
